// File: src/bqs_pkg.sv
// shared constants and types for the stereo biquad filter
package bqs_pkg;

   // default field widths
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEF_BITS_DEF   = 32;

   // register port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // register index codes (byte address / 4)
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEF_B0     = 3'd0,
      REG_COEF_B1     = 3'd1,
      REG_COEF_B2     = 3'd2,
      REG_COEF_A1     = 3'd3,
      REG_COEF_A2     = 3'd4,
      REG_STEREO_MODE = 3'd5
   } csr_reg_type;

endpackage

// File: src/bqs_csr.sv
// coefficient and mode registers behind the apb-style port
module bqs_csr #(
   parameter int COEF_BITS = bqs_pkg::COEF_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bqs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bqs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bqs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output logic signed [COEF_BITS-1:0]        coef_b0,
   output logic signed [COEF_BITS-1:0]        coef_b1,
   output logic signed [COEF_BITS-1:0]        coef_b2,
   output logic signed [COEF_BITS-1:0]        coef_a1,
   output logic signed [COEF_BITS-1:0]        coef_a2,
   output logic                               stereo_mode
);

   // unity gain in q4 format
   localparam logic [COEF_BITS-1:0] B0_RESET = {4'b0001, {(COEF_BITS-4){1'b0}}};

   logic [COEF_BITS-1:0]     b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic [COEF_BITS-1:0]     b0_in, b1_in, b2_in, a1_in, a2_in;
   logic                     stereo_ff, stereo_in;
   logic                     wr_en;
   bqs_pkg::csr_reg_type     reg_sel;
   logic [COEF_BITS-1:0]     wr_coef;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = bqs_pkg::csr_reg_type'(csr_paddr[bqs_pkg::CSR_IDX_W+1:2]);
   assign wr_coef    = csr_pwdata[COEF_BITS-1:0];

   // write decode
   always_comb begin
      b0_in     = b0_ff;
      b1_in     = b1_ff;
      b2_in     = b2_ff;
      a1_in     = a1_ff;
      a2_in     = a2_ff;
      stereo_in = stereo_ff;
      if (wr_en) begin
         unique case (reg_sel)
            bqs_pkg::REG_COEF_B0:     b0_in = wr_coef;
            bqs_pkg::REG_COEF_B1:     b1_in = wr_coef;
            bqs_pkg::REG_COEF_B2:     b2_in = wr_coef;
            bqs_pkg::REG_COEF_A1:     a1_in = wr_coef;
            bqs_pkg::REG_COEF_A2:     a2_in = wr_coef;
            bqs_pkg::REG_STEREO_MODE: stereo_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff     <= B0_RESET;
         b1_ff     <= '0;
         b2_ff     <= '0;
         a1_ff     <= '0;
         a2_ff     <= '0;
         stereo_ff <= 1'b0;
      end else begin
         b0_ff     <= b0_in;
         b1_ff     <= b1_in;
         b2_ff     <= b2_in;
         a1_ff     <= a1_in;
         a2_ff     <= a2_in;
         stereo_ff <= stereo_in;
      end
   end

   // read decode
   always_comb begin
      unique case (reg_sel)
         bqs_pkg::REG_COEF_B0:     csr_prdata = bqs_pkg::CSR_DATA_W'(b0_ff);
         bqs_pkg::REG_COEF_B1:     csr_prdata = bqs_pkg::CSR_DATA_W'(b1_ff);
         bqs_pkg::REG_COEF_B2:     csr_prdata = bqs_pkg::CSR_DATA_W'(b2_ff);
         bqs_pkg::REG_COEF_A1:     csr_prdata = bqs_pkg::CSR_DATA_W'(a1_ff);
         bqs_pkg::REG_COEF_A2:     csr_prdata = bqs_pkg::CSR_DATA_W'(a2_ff);
         bqs_pkg::REG_STEREO_MODE: csr_prdata = bqs_pkg::CSR_DATA_W'(stereo_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   assign coef_b0     = b0_ff;
   assign coef_b1     = b1_ff;
   assign coef_b2     = b2_ff;
   assign coef_a1     = a1_ff;
   assign coef_a2     = a2_ff;
   assign stereo_mode = stereo_ff;

endmodule

// File: src/bqs_mac.sv
// five-tap multiply-accumulate with truncation and saturation to sample range
module bqs_mac #(
   parameter int SAMPLE_BITS = bqs_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = bqs_pkg::COEF_BITS_DEF
) (
   input  logic signed [SAMPLE_BITS-1:0] x0,
   input  logic signed [SAMPLE_BITS-1:0] x1,
   input  logic signed [SAMPLE_BITS-1:0] x2,
   input  logic signed [SAMPLE_BITS-1:0] y1,
   input  logic signed [SAMPLE_BITS-1:0] y2,
   input  logic signed [COEF_BITS-1:0]   coef_b0,
   input  logic signed [COEF_BITS-1:0]   coef_b1,
   input  logic signed [COEF_BITS-1:0]   coef_b2,
   input  logic signed [COEF_BITS-1:0]   coef_a1,
   input  logic signed [COEF_BITS-1:0]   coef_a2,
   output logic signed [SAMPLE_BITS-1:0] y0
);

   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W  = PROD_W + 3;
   localparam int FRAC   = COEF_BITS - 4;
   localparam int SHR_W  = ACC_W - FRAC;

   localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
   logic signed [ACC_W-1:0]  acc;
   logic signed [SHR_W-1:0]  shr;
   logic [SHR_W-SAMPLE_BITS:0] top_bits;
   logic                     in_range;

   // full-precision products
   assign p_b0 = PROD_W'(coef_b0) * PROD_W'(x0);
   assign p_b1 = PROD_W'(coef_b1) * PROD_W'(x1);
   assign p_b2 = PROD_W'(coef_b2) * PROD_W'(x2);
   assign p_a1 = PROD_W'(coef_a1) * PROD_W'(y1);
   assign p_a2 = PROD_W'(coef_a2) * PROD_W'(y2);

   // exact sum, feedback terms subtracted
   assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
              - ACC_W'(p_a1) - ACC_W'(p_a2);

   // floor to sample format, then clamp
   assign shr      = acc[ACC_W-1:FRAC];
   assign top_bits = shr[SHR_W-1:SAMPLE_BITS-1];
   assign in_range = (top_bits == '0) || (top_bits == '1);

   always_comb begin
      if (in_range) begin
         y0 = shr[SAMPLE_BITS-1:0];
      end else if (shr[SHR_W-1]) begin
         y0 = SAT_MIN;
      end else begin
         y0 = SAT_MAX;
      end
   end

endmodule

// File: src/biquad_iir_filter_stereo_core.sv
// stereo biquad top: input register, filter datapath, channel history, result register
//
//   channel  | ports          | payload                         | handshake
//   request  | req_*          | sample_in                       | valid / stall
//   result   | rsp_*          | sample_out, right_channel       | valid / stall
//   config   | csr_*          | b0 b1 b2 a1 a2, stereo_mode     | apb-style, pready tied high
//
// one request per clock unless the result stalls; requests go from input register to result register.
// the whole five-product sum and clamp sit between the input register and result register,
// so the y1 feedback of a channel is ready for that channel's very next request.
// synchronous reset clears coefficients to unity gain, all history to zero, toggle to left.
// a stalled result holds; one more request is still taken into the input register.
module biquad_iir_filter_stereo_core #(
   parameter int SAMPLE_BITS = bqs_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = bqs_pkg::COEF_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [SAMPLE_BITS-1:0]    req_sample_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]    rsp_sample_out,
   output logic                             rsp_right_channel,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bqs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bqs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bqs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   logic signed [COEF_BITS-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
   logic                          stereo_mode;

   logic                          s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff, s1_sample_in;
   logic                          s1_right_ff, s1_right_in;
   logic                          toggle_ff, toggle_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_right_ff, rsp_right_in;

   // history per channel: index 0 left, 1 right
   logic signed [SAMPLE_BITS-1:0] x1_ff [2];
   logic signed [SAMPLE_BITS-1:0] x2_ff [2];
   logic signed [SAMPLE_BITS-1:0] y1_ff [2];
   logic signed [SAMPLE_BITS-1:0] y2_ff [2];
   logic signed [SAMPLE_BITS-1:0] x1_in [2];
   logic signed [SAMPLE_BITS-1:0] x2_in [2];
   logic signed [SAMPLE_BITS-1:0] y1_in [2];
   logic signed [SAMPLE_BITS-1:0] y2_in [2];

   logic                          out_free;
   logic                          s1_adv;
   logic                          req_take;
   logic signed [SAMPLE_BITS-1:0] y_new;

   bqs_csr #(
      .COEF_BITS (COEF_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef_b0     (coef_b0),
      .coef_b1     (coef_b1),
      .coef_b2     (coef_b2),
      .coef_a1     (coef_a1),
      .coef_a2     (coef_a2),
      .stereo_mode (stereo_mode)
   );

   // handshake: result register frees when empty or being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // input register and channel toggle
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_sample_in = s1_sample_ff;
      s1_right_in  = s1_right_ff;
      toggle_in    = toggle_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in  = 1'b1;
         s1_sample_in = req_sample_in;
         s1_right_in  = stereo_mode && toggle_ff;
         toggle_in    = stereo_mode && !toggle_ff;
      end
   end

   // filter datapath on the selected channel history
   bqs_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_mac (
      .x0      (s1_sample_ff),
      .x1      (x1_ff[s1_right_ff]),
      .x2      (x2_ff[s1_right_ff]),
      .y1      (y1_ff[s1_right_ff]),
      .y2      (y2_ff[s1_right_ff]),
      .coef_b0 (coef_b0),
      .coef_b1 (coef_b1),
      .coef_b2 (coef_b2),
      .coef_a1 (coef_a1),
      .coef_a2 (coef_a2),
      .y0      (y_new)
   );

   // history shift and result register load
   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      y1_in = y1_ff;
      y2_in = y2_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_right_in  = rsp_right_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv) begin
         x2_in[s1_right_ff] = x1_ff[s1_right_ff];
         x1_in[s1_right_ff] = s1_sample_ff;
         y2_in[s1_right_ff] = y1_ff[s1_right_ff];
         y1_in[s1_right_ff] = y_new;
         rsp_valid_in  = 1'b1;
         rsp_sample_in = y_new;
         rsp_right_in  = s1_right_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         toggle_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            x1_ff[i] <= '0;
            x2_ff[i] <= '0;
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         toggle_ff    <= toggle_in;
         rsp_valid_ff <= rsp_valid_in;
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_sample_ff  <= s1_sample_in;
      s1_right_ff   <= s1_right_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_right_ff  <= rsp_right_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_right_channel = rsp_right_ff;

   // checks
   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty input register");

   a_adv_fills_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("advanced request did not reach result register");

   a_mono_is_left: assert property (@(posedge clock) disable iff (reset)
      (req_take && !stereo_mode) |=> (!s1_right_ff && !toggle_ff))
      else $error("mono request routed to right channel");

   a_stereo_alternates: assert property (@(posedge clock) disable iff (reset)
      (req_take && stereo_mode) |=> (toggle_ff != $past(toggle_ff)))
      else $error("stereo toggle did not alternate");

   a_result_in_history: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sample_ff == y1_ff[rsp_right_ff]))
      else $error("pending result differs from channel feedback history");

endmodule
